// ----- src/wng_pkg.sv -----
package wng_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned SEED_W      = 64;
  localparam int unsigned FRAME_W     = 32;
  localparam int unsigned FCOUNT_W    = 31;
  localparam int unsigned PIXEL_W     = 24;
  localparam int unsigned WELL_WORDS  = 16;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned CFG_W       = 32;
  localparam int unsigned OUT_DATA_W  = 56;

  localparam logic [SEED_W-1:0]   LCG_MUL     = 64'd6364136223846793005;
  localparam logic [SEED_W-1:0]   LCG_ADD     = 64'd1442695040888963407;
  localparam logic [WORD_W-1:0]   FRAME_MUL   = 32'd4562693;
  localparam logic [WORD_W-1:0]   WELL_MASK   = 32'hDA442D24;
  localparam logic [FCOUNT_W-1:0] FCOUNT_RST  = 31'd86400;

  localparam int unsigned LCG_WARMUP  = 13;
  localparam int unsigned WELL_WARMUP = 7;

  localparam logic [CNT_W-1:0] CNT_WARM = CNT_W'(LCG_WARMUP - 1);
  localparam logic [CNT_W-1:0] CNT_FILL = CNT_W'(WELL_WORDS - 1);
  localparam logic [CNT_W-1:0] CNT_WELL = CNT_W'(WELL_WARMUP - 1);

  // taps relative to the current WELL position
  localparam int unsigned TAP_Y    = 13;
  localparam int unsigned TAP_T    = 9;
  localparam int unsigned TAP_PREV = 15;

  typedef enum logic {
    REQ_RESEED = 1'b0,
    REQ_DRAW   = 1'b1
  } req_e;

  typedef enum logic {
    CFG_USER_SEED   = 1'b0,
    CFG_FRAME_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_FRAME,
    ST_SEED_INIT,
    ST_WARM_LL,
    ST_WARM_LH,
    ST_WARM_HL,
    ST_WARM_SUM,
    ST_FILL_LL,
    ST_FILL_LH,
    ST_FILL_HL,
    ST_FILL_SUM,
    ST_WELL
  } step_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FRAME,
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD_HI
  } acc_op_e;

  typedef enum logic [1:0] {
    SEED_NONE,
    SEED_INIT,
    SEED_STEP
  } seed_op_e;

  typedef enum logic [1:0] {
    JMP_WAIT,
    JMP_NEXT,
    JMP_LOOP
  } jump_e;

  typedef struct packed {
    mul_sel_e         mul_sel;
    acc_op_e          acc_op;
    seed_op_e         seed_op;
    logic             fill;
    logic             well_step;
    logic             cnt_load;
    logic [CNT_W-1:0] cnt_val;
    jump_e            jump;
    step_e            next_step;
    step_e            loop_step;
  } ctrl_t;

endpackage

// ----- src/wng_seq.sv -----
module wng_seq import wng_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output ctrl_t ctrl_o,
  output logic  idle_o
);

  step_e            step_q, step_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  ctrl_t            cw;

  function automatic ctrl_t rom(input step_e s);
    ctrl_t c;
    c = '{mul_sel: MUL_NONE, acc_op: ACC_NONE, seed_op: SEED_NONE, fill: 1'b0,
          well_step: 1'b0, cnt_load: 1'b0, cnt_val: '0, jump: JMP_NEXT,
          next_step: ST_IDLE, loop_step: ST_IDLE};
    case (s)
      ST_IDLE: begin
        c.jump      = JMP_WAIT;
        c.next_step = ST_MUL_FRAME;
      end
      ST_MUL_FRAME: begin
        c.mul_sel   = MUL_FRAME;
        c.next_step = ST_SEED_INIT;
      end
      ST_SEED_INIT: begin
        c.seed_op   = SEED_INIT;
        c.cnt_load  = 1'b1;
        c.cnt_val   = CNT_WARM;
        c.next_step = ST_WARM_LL;
      end
      ST_WARM_LL: begin
        c.mul_sel   = MUL_LL;
        c.next_step = ST_WARM_LH;
      end
      ST_WARM_LH: begin
        c.mul_sel   = MUL_LH;
        c.acc_op    = ACC_LOAD;
        c.next_step = ST_WARM_HL;
      end
      ST_WARM_HL: begin
        c.mul_sel   = MUL_HL;
        c.acc_op    = ACC_ADD_HI;
        c.next_step = ST_WARM_SUM;
      end
      ST_WARM_SUM: begin
        c.seed_op   = SEED_STEP;
        c.jump      = JMP_LOOP;
        c.loop_step = ST_WARM_LL;
        c.cnt_load  = 1'b1;
        c.cnt_val   = CNT_FILL;
        c.next_step = ST_FILL_LL;
      end
      ST_FILL_LL: begin
        c.mul_sel   = MUL_LL;
        c.next_step = ST_FILL_LH;
      end
      ST_FILL_LH: begin
        c.mul_sel   = MUL_LH;
        c.acc_op    = ACC_LOAD;
        c.next_step = ST_FILL_HL;
      end
      ST_FILL_HL: begin
        c.mul_sel   = MUL_HL;
        c.acc_op    = ACC_ADD_HI;
        c.next_step = ST_FILL_SUM;
      end
      ST_FILL_SUM: begin
        c.seed_op   = SEED_STEP;
        c.fill      = 1'b1;
        c.jump      = JMP_LOOP;
        c.loop_step = ST_FILL_LL;
        c.cnt_load  = 1'b1;
        c.cnt_val   = CNT_WELL;
        c.next_step = ST_WELL;
      end
      ST_WELL: begin
        c.well_step = 1'b1;
        c.jump      = JMP_LOOP;
        c.loop_step = ST_WELL;
        c.next_step = ST_IDLE;
      end
      default: begin
        c.next_step = ST_IDLE;
      end
    endcase
    return c;
  endfunction

  assign cw     = rom(step_q);
  assign ctrl_o = cw;
  assign idle_o = (step_q == ST_IDLE);

  always_comb begin
    step_d = step_q;
    cnt_d  = cnt_q;
    case (cw.jump)
      JMP_WAIT: begin
        if (start_i) begin
          step_d = cw.next_step;
        end
      end
      JMP_NEXT: begin
        step_d = cw.next_step;
        if (cw.cnt_load) begin
          cnt_d = cw.cnt_val;
        end
      end
      JMP_LOOP: begin
        if (cnt_q != '0) begin
          cnt_d  = cnt_q - CNT_W'(1);
          step_d = cw.loop_step;
        end else begin
          step_d = cw.next_step;
          if (cw.cnt_load) begin
            cnt_d = cw.cnt_val;
          end
        end
      end
      default: begin
        step_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
      cnt_q  <= '0;
    end else begin
      step_q <= step_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- src/wng_lcg.sv -----
module wng_lcg import wng_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  input  logic                load_i,
  input  logic [FRAME_W-1:0]  frame_i,
  input  logic [WORD_W-1:0]   user_seed_i,
  input  logic [FCOUNT_W-1:0] frame_count_i,
  output logic [WORD_W-1:0]   fill_word_o
);

  logic [FCOUNT_W-1:0] n_q, n_d;
  logic [SEED_W-1:0]   prod_q;
  logic [SEED_W-1:0]   acc_q, acc_d;
  logic [SEED_W-1:0]   seed_q, seed_d;
  logic [WORD_W-1:0]   mul_a, mul_b;
  logic [SEED_W-1:0]   mul_res;
  logic [WORD_W-1:0]   seed_hi_next;

  // frame clamp
  always_comb begin
    if (frame_i[FRAME_W-1] || (frame_count_i == '0)) begin
      n_d = '0;
    end else if (frame_i[FCOUNT_W-1:0] >= frame_count_i) begin
      n_d = frame_count_i - FCOUNT_W'(1);
    end else begin
      n_d = frame_i[FCOUNT_W-1:0];
    end
  end

  // one shared 32x32 multiplier, low 64 bits of the seed product in three parts
  always_comb begin
    mul_a = seed_q[WORD_W-1:0];
    mul_b = LCG_MUL[WORD_W-1:0];
    case (ctrl_i.mul_sel)
      MUL_FRAME: begin
        mul_a = {1'b0, n_q} + WORD_W'(1);
        mul_b = FRAME_MUL;
      end
      MUL_LH: begin
        mul_b = LCG_MUL[SEED_W-1:WORD_W];
      end
      MUL_HL: begin
        mul_a = seed_q[SEED_W-1:WORD_W];
      end
      default: begin
      end
    endcase
  end

  assign mul_res      = mul_a * mul_b;
  assign seed_hi_next = acc_q[SEED_W-1:WORD_W] + prod_q[WORD_W-1:0];
  assign fill_word_o  = seed_hi_next;

  always_comb begin
    acc_d = acc_q;
    case (ctrl_i.acc_op)
      ACC_LOAD:   acc_d = prod_q + LCG_ADD;
      ACC_ADD_HI: acc_d = {seed_hi_next, acc_q[WORD_W-1:0]};
      default:    acc_d = acc_q;
    endcase
  end

  always_comb begin
    seed_d = seed_q;
    case (ctrl_i.seed_op)
      SEED_INIT: seed_d = {{WORD_W{1'b0}}, prod_q[WORD_W-1:0] + user_seed_i};
      SEED_STEP: seed_d = {seed_hi_next, acc_q[WORD_W-1:0]};
      default:   seed_d = seed_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else begin
      seed_q <= seed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      n_q <= n_d;
    end
    if (ctrl_i.mul_sel != MUL_NONE) begin
      prod_q <= mul_res;
    end
    acc_q <= acc_d;
  end

endmodule

// ----- src/wng_well.sv -----
module wng_well import wng_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              fill_i,
  input  logic [WORD_W-1:0] fill_word_i,
  output logic [WORD_W-1:0] word_o
);

  // s_q[k] holds the state word k places after the current position
  logic [WORD_W-1:0] s_q [WELL_WORDS];
  logic [WORD_W-1:0] s_d [WELL_WORDS];
  logic [WORD_W-1:0] x, y, t0, t, mixed, nx, d, prev, z;

  assign x     = s_q[0];
  assign y     = s_q[TAP_Y];
  assign t0    = s_q[TAP_T];
  assign prev  = s_q[TAP_PREV];
  assign mixed = x ^ y ^ (x << 16) ^ (y << 15);
  assign t     = t0 ^ (t0 >> 11);
  assign nx    = mixed ^ t;
  assign d     = nx ^ ((nx << 5) & WELL_MASK);
  assign z     = prev ^ mixed ^ d ^ (prev << 2) ^ (mixed << 18) ^ (t << 28);
  assign word_o = z;

  always_comb begin
    for (int k = 0; k < WELL_WORDS; k++) begin
      s_d[k] = s_q[k];
    end
    if (step_i) begin
      s_d[0] = z;
      s_d[1] = nx;
      for (int k = 2; k < WELL_WORDS; k++) begin
        s_d[k] = s_q[k-1];
      end
    end else if (fill_i) begin
      for (int k = 0; k < WELL_WORDS - 1; k++) begin
        s_d[k] = s_q[k+1];
      end
      s_d[WELL_WORDS-1] = fill_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WELL_WORDS; k++) begin
        s_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < WELL_WORDS; k++) begin
        s_q[k] <= s_d[k];
      end
    end
  end

endmodule

// ----- src/well512_noise_generator.sv -----
// Channel    Dir  Signals                    Contents
// s_axis     in   tvalid/tready/tdata/tuser  tdata[31:0] frame_number, tuser req_type
// m_axis     out  tvalid/tready/tdata        tdata[31:0] random_word, [55:32] pixel_value
// cfg        in   we/idx/wdata               0 user_seed, 1 frame_count (wdata[30:0])
//
// A draw steps the WELL state; its result goes to an output register.
// A reseed after acceptance runs 2 seed setup steps, 29 LCG steps (states LL, LH,
// HL, SUM each) on one shared 32x32 multiplier, then 7 WELL steps. No request is
// accepted while a reseed runs; a draw also waits while a held result is not taken.
// Reset is asynchronous, active low; frame_count resets to 86400, seeds and WELL to zero.
module well512_noise_generator import wng_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [FRAME_W-1:0]    s_axis_tdata_i,   // [31:0] frame_number
  input  logic                  s_axis_tuser_i,   // [0] req_type
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // [31:0] random_word, [55:32] pixel_value
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  ctrl_t               ctrl;
  logic                idle;
  logic                accept, start, draw;
  logic [WORD_W-1:0]   user_seed_q;
  logic [FCOUNT_W-1:0] frame_count_q;
  logic [WORD_W-1:0]   fill_word, well_word;
  logic                out_valid_q, out_valid_d;
  logic [WORD_W-1:0]   out_word_q;

  assign s_axis_tready_o = idle && ((s_axis_tuser_i == REQ_RESEED) ||
                                    !out_valid_q || m_axis_tready_i);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign start  = accept && (s_axis_tuser_i == REQ_RESEED);
  assign draw   = accept && (s_axis_tuser_i == REQ_DRAW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_seed_q   <= '0;
      frame_count_q <= FCOUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_USER_SEED:   user_seed_q   <= cfg_wdata_i;
        CFG_FRAME_COUNT: frame_count_q <= cfg_wdata_i[FCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wng_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .ctrl_o  (ctrl),
    .idle_o  (idle)
  );

  wng_lcg u_lcg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .load_i        (start),
    .frame_i       (s_axis_tdata_i),
    .user_seed_i   (user_seed_q),
    .frame_count_i (frame_count_q),
    .fill_word_o   (fill_word)
  );

  wng_well u_well (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (ctrl.well_step || draw),
    .fill_i      (ctrl.fill),
    .fill_word_i (fill_word),
    .word_o      (well_word)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (draw) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw) begin
      out_word_q <= well_word;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_word_q[PIXEL_W-1:0], out_word_q};

endmodule

// ----- src/wng_checker.sv -----
module wng_checker import wng_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [FRAME_W-1:0]    s_axis_tdata_i,
  input logic                  s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  cfg_we_i,
  input logic                  cfg_idx_i,
  input logic [CFG_W-1:0]      cfg_wdata_i
);

  logic unused_ok;
  assign unused_ok = ^{s_axis_tdata_i, cfg_we_i, cfg_idx_i, cfg_wdata_i};

  a_pixel_low_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[OUT_DATA_W-1:WORD_W] ==
                         m_axis_tdata_o[PIXEL_W-1:0]))
    else $error("pixel_value differs from low bits of random_word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  a_reseed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == REQ_RESEED)) |=>
      !s_axis_tready_o)
    else $error("request accepted right after a reseed");

  a_draw_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == REQ_DRAW)) |=>
      m_axis_tvalid_o)
    else $error("draw gave no result");

endmodule

bind well512_noise_generator wng_checker u_wng_checker (.*);

// ----- test/tb_top.sv -----
module tb_top;
  import wng_pkg::*;

  localparam logic [63:0] MMIX_MUL    = 64'd6364136223846793005;
  localparam logic [63:0] MMIX_ADD    = 64'd1442695040888963407;
  localparam logic [31:0] FRAME_STEP  = 32'd4562693;
  localparam logic [31:0] TEMPER_MASK = 32'hDA442D24;
  localparam int          RESEED_WAIT = 130;
  localparam int          STALL_LIMIT = 4000;
  localparam int          HOLD_CYCLES = 400;

  typedef struct packed {
    logic [31:0] word;
    logic [23:0] pixel;
  } draw_result_t;

  typedef struct packed {
    req_e        kind;
    logic [31:0] frame;
    logic        fixed;
    logic [31:0] word;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [FRAME_W-1:0]    s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_idx_i = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;

  // shadow of the generator
  logic [31:0] seed_user   = 32'd0;
  logic [30:0] frame_total = 31'd86400;
  logic [63:0] lcg_seed    = 64'd0;
  logic [31:0] well_st [16];
  logic [3:0]  well_ptr    = 4'd0;

  draw_result_t draw_q [$];
  int  mismatch_cnt  = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_left     = 0;
  int  stall_cycles  = 0;
  bit  hold_req      = 1'b0;
  bit  tx_busy       = 1'b0;

  // draws on the zero state return zero
  plan_row_t plan [20] = '{
    '{REQ_DRAW,   32'h0000_0000, 1'b1, 32'h0},
    '{REQ_DRAW,   32'hFFFF_FFFF, 1'b1, 32'h0},
    '{REQ_RESEED, 32'h8000_0000, 1'b0, 32'h0},
    '{REQ_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{REQ_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{REQ_RESEED, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{REQ_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{REQ_RESEED, 32'h0000_0000, 1'b0, 32'h0},
    '{REQ_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{REQ_RESEED, 32'd86399,     1'b0, 32'h0},
    '{REQ_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{REQ_RESEED, 32'd86400,     1'b0, 32'h0},
    '{REQ_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{REQ_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{REQ_RESEED, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{REQ_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{REQ_RESEED, 32'h0000_0001, 1'b0, 32'h0},
    '{REQ_RESEED, 32'h0000_0001, 1'b0, 32'h0},
    '{REQ_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{REQ_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0}
  };

  well512_noise_generator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [31:0] well_advance();
    logic [3:0]  p, py, pt, q;
    logic [31:0] x, y, mixed, t, d;
    p  = well_ptr;
    py = p + 4'd13;
    pt = p + 4'd9;
    x = well_st[p];
    y = well_st[py];
    mixed = x ^ y ^ (x << 16) ^ (y << 15);
    t = well_st[pt];
    t = t ^ (t >> 11);
    x = mixed ^ t;
    well_st[p] = x;
    d = x ^ ((x << 5) & TEMPER_MASK);
    q = p + 4'd15;
    well_ptr = q;
    x = well_st[q];
    well_st[q] = x ^ mixed ^ d ^ (x << 2) ^ (mixed << 18) ^ (t << 28);
    return well_st[q];
  endfunction

  function automatic logic [31:0] lcg_advance();
    lcg_seed = lcg_seed * MMIX_MUL + MMIX_ADD;
    return lcg_seed[63:32];
  endfunction

  function automatic void reseed_frame(logic [31:0] raw);
    logic [31:0] n, s, w;
    if (raw[31] || frame_total == '0) begin
      n = 32'd0;
    end else if (raw >= {1'b0, frame_total}) begin
      n = {1'b0, frame_total} - 32'd1;
    end else begin
      n = raw;
    end
    s = (n + 32'd1) * FRAME_STEP + seed_user;
    lcg_seed = {32'd0, s};
    for (int i = 0; i < 13; i++) w = lcg_advance();
    for (int i = 0; i < 16; i++) well_st[i] = lcg_advance();
    well_ptr = 4'd0;
    for (int i = 0; i < 7; i++) w = well_advance();
  endfunction

  function automatic logic [31:0] pick_frame();
    logic [31:0] fc;
    fc = {1'b0, frame_total};
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom;
      2: return fc + 32'($urandom_range(2)) - 32'd1;
      3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom % fc;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_cnt < 40)
      $display("ERROR %s: got %08h exp %08h at %0t", what, got, want, $time);
    mismatch_cnt++;
  endtask

  task automatic check_draw(logic [OUT_DATA_W-1:0] data);
    draw_result_t want;
    if (draw_q.size() == 0) begin
      report_mismatch("unexpected result", data[31:0], 32'd0);
      return;
    end
    want = draw_q.pop_front();
    if (data[31:0] !== want.word)
      report_mismatch("random_word", data[31:0], want.word);
    if (data[55:32] !== want.pixel)
      report_mismatch("pixel_value", 32'(data[55:32]), 32'(want.pixel));
  endtask

  task automatic send_req(req_e kind, logic [31:0] frame, bit fixed, logic [31:0] fixed_word);
    int           gap;
    logic [31:0]  w;
    draw_result_t res;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= frame;
    s_axis_tuser_i  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (kind == REQ_RESEED) begin
      reseed_frame(frame);
    end else begin
      w = well_advance();
      if (fixed) w = fixed_word;
      res.word  = w;
      res.pixel = w[23:0];
      draw_q.push_back(res);
    end
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      tx_busy = 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      tx_busy = 1'b1;
    end
  endtask

  // a reseed gives no result, so leave room for one still running
  task automatic drain();
    if (tx_busy) begin
      s_axis_tvalid_i <= 1'b0;
      tx_busy = 1'b0;
    end
    while (draw_q.size() != 0) @(posedge clk_i);
    repeat (RESEED_WAIT) @(posedge clk_i);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, logic [31:0] useed,
                           logic [30:0] fcount, int n_items, bit stall);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_USER_SEED;
    cfg_wdata_i <= useed;
    @(posedge clk_i);
    seed_user = useed;
    cfg_idx_i   <= CFG_FRAME_COUNT;
    cfg_wdata_i <= {1'b0, fcount};
    @(posedge clk_i);
    frame_total = fcount;
    cfg_we_i <= 1'b0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (stall) hold_req = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 8) send_req(REQ_RESEED, pick_frame(), 1'b0, 32'd0);
      else send_req(REQ_DRAW, $urandom, 1'b0, 32'd0);
    end
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) check_draw(m_axis_tdata_o);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("well512_noise_generator: mismatch");
      $finish;
    end
  end

  initial begin
    foreach (well_st[i]) well_st[i] = 32'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 12;
    recv_idle_pct = 64;
    foreach (plan[i]) send_req(plan[i].kind, plan[i].frame, plan[i].fixed, plan[i].word);

    run_phase(12, 64, 32'hFFFF_FFFF, 31'd1, 350, 1'b1);
    run_phase(12, 64, $urandom, 31'($urandom_range(2, 100000)), 300, 1'b0);
    run_phase(64, 12, $urandom, 31'h7FFF_FFFF, 350, 1'b0);
    run_phase(64, 12, 32'd0, 31'($urandom_range(1, 64)), 300, 1'b0);
    run_phase(0, 0, $urandom, 31'($urandom_range(1, 32'h7FFF_FFFF)), 450, 1'b0);

    drain();
    if (mismatch_cnt == 0) begin
      $display("well512_noise_generator: match");
    end else begin
      $display("well512_noise_generator: mismatch");
    end
    $finish;
  end

endmodule
